/* rtl/base64_stream_decoder_macros.svh */
// assertion macros for the base64 stream decoder
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define B64D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define B64D_ASSERT(lbl, prop, msg)
`define B64D_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/b64d_pkg.sv */
// shared types and constants of the base64 stream decoder
package b64d_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned VAL_W  = 6;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

  // one classified character on its way from front to back
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             bad;
    logic             pad;
    logic             last;
    logic             url;
  } b64d_entry_t;

endpackage

/* rtl/b64d_in_if.sv */
// input character channel
interface b64d_in_if;
  logic                           valid;
  logic                           ready;
  logic [b64d_pkg::CHAR_W-1:0]    in_char;
  logic                           in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

/* rtl/b64d_out_if.sv */
// decoded result channel
interface b64d_out_if;
  logic                           valid;
  logic                           ready;
  logic [b64d_pkg::BYTE_W-1:0]    out_byte;
  logic                           byte_valid;
  logic                           done_res;
  logic                           error;

  modport source (output valid, output out_byte, output byte_valid, output done_res,
                  output error, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input done_res,
                  input error, output ready);
endinterface

/* rtl/b64d_cfg_if.sv */
// configuration write channel
interface b64d_cfg_if;
  logic valid;
  logic ready;
  logic url_alphabet;

  modport source (output valid, output url_alphabet, input ready);
  modport sink   (input valid, input url_alphabet, output ready);
endinterface

/* rtl/b64d_front.sv */
// front end: alphabet register, character classification and queue push
module b64d_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  b64d_in_if.sink               in_if,
  b64d_cfg_if.sink              cfg_if,
  input  logic                  full_i,
  output logic                  push_o,
  output b64d_pkg::b64d_entry_t entry_o
);
  import b64d_pkg::*;

  logic url_q;

  // alphabet select register, url-safe after reset
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      url_q <= 1'b1;
    end else if (cfg_if.valid) begin
      url_q <= cfg_if.url_alphabet;
    end
  end

  // accept a beat whenever the queue has room
  assign in_if.ready = !full_i;
  assign push_o      = in_if.valid && !full_i;

  // map the character to its 6-bit value
  always_comb begin
    logic [CHAR_W-1:0] c;
    c             = in_if.in_char;
    entry_o.value = '0;
    entry_o.bad   = 1'b1;
    entry_o.pad   = 1'b0;
    entry_o.last  = in_if.in_last;
    entry_o.url   = url_q;
    if (c >= 8'h41 && c <= 8'h5A) begin
      // upper case letters
      entry_o.value = VAL_W'(c - 8'h41);
      entry_o.bad   = 1'b0;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      // lower case letters start at 26
      entry_o.value = VAL_W'(c - 8'h47);
      entry_o.bad   = 1'b0;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      // digits start at 52
      entry_o.value = VAL_W'(c + 8'h04);
      entry_o.bad   = 1'b0;
    end else if (c == (url_q ? 8'h2D : 8'h2B)) begin
      entry_o.value = 6'd62;
      entry_o.bad   = 1'b0;
    end else if (c == (url_q ? 8'h5F : 8'h2F)) begin
      entry_o.value = 6'd63;
      entry_o.bad   = 1'b0;
    end else if (!url_q && c == PAD_CHAR) begin
      // padding only exists in standard mode
      entry_o.pad   = 1'b1;
      entry_o.bad   = 1'b0;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
// small fifo between the front and the back
module b64d_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  b64d_pkg::b64d_entry_t    entry_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output b64d_pkg::b64d_entry_t    entry_o,
  output logic                     full_o,
  output logic [$clog2(DEPTH):0]   count_o
);
  import b64d_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  b64d_entry_t        mem_q [DEPTH];
  logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [AW:0]        count_q;

  // storage, written at the tail
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign entry_o = mem_q[rd_ptr_q];
  assign valid_o = count_q != '0;
  assign full_o  = count_q == (AW+1)'(DEPTH);
  assign count_o = count_q;

endmodule

/* rtl/b64d_back.sv */
// back end: quartet tracking, bit packing, error rules and output register
module b64d_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  b64d_pkg::b64d_entry_t entry_i,
  output logic                  pop_o,
  b64d_out_if.source            out_if
);
  import b64d_pkg::*;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  logic [1:0]        pos_q, pos_d;
  logic [VAL_W-1:0]  left_q, left_d;
  logic [1:0]        pad_cnt_q, pad_cnt_d;
  logic              err_q, err_d;

  logic              out_valid_q;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              byte_valid_q, byte_valid_d;
  logic              done_q;
  logic              error_q;
  logic              emit;

  // take the next entry when the output slot is free or being drained
  assign pop_o = valid_i && (!out_valid_q || out_if.ready);

  // state update for one character
  always_comb begin
    pos_d        = pos_q + 2'd1;
    left_d       = left_q;
    pad_cnt_d    = pad_cnt_q;
    err_d        = err_q;
    byte_d       = '0;
    byte_valid_d = 1'b0;
    if (entry_i.pad) begin
      if (pos_q == POS_FIRST || pos_q == POS_SECOND) begin
        err_d = 1'b1;
      end
      pad_cnt_d = pad_cnt_q + 2'd1;
      left_d    = '0;
    end else begin
      if (entry_i.bad || pad_cnt_q != 2'd0) begin
        err_d = 1'b1;
      end
      case (pos_q)
        POS_FIRST: begin
          left_d = entry_i.value;
        end
        POS_SECOND: begin
          byte_d       = {left_q, entry_i.value[5:4]};
          left_d       = {2'b00, entry_i.value[3:0]};
          byte_valid_d = 1'b1;
        end
        POS_THIRD: begin
          byte_d       = {left_q[3:0], entry_i.value[5:2]};
          left_d       = {4'b0000, entry_i.value[1:0]};
          byte_valid_d = 1'b1;
        end
        POS_FOURTH: begin
          byte_d       = {left_q[1:0], entry_i.value};
          left_d       = '0;
          byte_valid_d = 1'b1;
        end
        default: begin
          left_d = '0;
        end
      endcase
    end
    // length rules at the end of the string
    if (entry_i.last) begin
      if (!entry_i.url && pos_d != POS_FIRST) begin
        err_d = 1'b1;
      end
      if (entry_i.url && pos_d == POS_SECOND) begin
        err_d = 1'b1;
      end
    end
  end

  assign emit = byte_valid_d || entry_i.last;

  // stream state, cleared after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_FIRST;
      left_q    <= '0;
      pad_cnt_q <= '0;
      err_q     <= 1'b0;
    end else if (pop_o) begin
      if (entry_i.last) begin
        pos_q     <= POS_FIRST;
        left_q    <= '0;
        pad_cnt_q <= '0;
        err_q     <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        left_q    <= left_d;
        pad_cnt_q <= pad_cnt_d;
        err_q     <= err_d;
      end
    end
  end

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      byte_q       <= byte_d;
      byte_valid_q <= byte_valid_d;
      done_q       <= entry_i.last;
      error_q      <= err_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_byte   = byte_q;
  assign out_if.byte_valid = byte_valid_q;
  assign out_if.done_res   = done_q;
  assign out_if.error      = error_q;

endmodule

/* rtl/base64_stream_decoder.sv */
// Base64 stream decoder, one character beat in, at most one byte beat out.
// Throughput: one character per cycle, sustained while the output side takes beats.
// A character enters the queue at its accepting edge and moves on to the output register when the back
// end pops it; its result beat, if it makes one, is valid once it sits in the output register.
// Reset: queue empty, stream state cleared, url_alphabet set to 1 (url-safe).
// Queue depth QUEUE_DEPTH (power of two, 2 to 16) sets how long the front rides a stall.
`include "base64_stream_decoder_macros.svh"

module base64_stream_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64d_in_if.sink     in_if,
  b64d_cfg_if.sink    cfg_if,
  b64d_out_if.source  out_if
);
  import b64d_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  logic              push;
  logic              pop;
  logic              full;
  logic              q_valid;
  logic [AW:0]       q_count;
  b64d_entry_t       push_entry;
  b64d_entry_t       pop_entry;

  // classify incoming characters
  b64d_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .cfg_if  (cfg_if),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // decouple front and back
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (pop_entry),
    .full_o  (full),
    .count_o (q_count)
  );

  // decode and emit
  b64d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_if  (out_if)
  );

  // a beat without a byte only ever closes a string
  `B64D_ASSERT(a_nobyte_is_done, out_if.valid && !out_if.byte_valid |-> out_if.done_res, "result beat without byte and without done")
  // bytes outside a decode read as zero
  `B64D_ASSERT(a_nobyte_zero, out_if.valid && !out_if.byte_valid |-> out_if.out_byte == '0, "empty result beat carries a nonzero byte")
  // queue level never exceeds its depth
  `B64D_ASSERT_ALWAYS(a_queue_bound, q_count <= (AW+1)'(QUEUE_DEPTH), "queue fill level beyond depth")
  // fill level rises by one after an edge with a push and no pop
  `B64D_ASSERT(a_queue_track, $past(push) && !$past(pop) |-> q_count == $past(q_count) + 1'b1, "queue level missed a push")

endmodule
